@@ rtl/seig_pkg.sv @@
// Shared types and codes for the stream entry ID generator.
package seig_pkg;

    localparam logic [1:0] MODE_AUTO     = 2'd0;
    localparam logic [1:0] MODE_PARTIAL  = 2'd1;
    localparam logic [1:0] MODE_EXPLICIT = 2'd2;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_GT   = 2'd1,
        ST_ZERO_ID  = 2'd2,
        ST_NO_FIELD = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [63:0] req_time;
        logic [63:0] req_seq;
        logic [63:0] now_ms;
        logic        has_fields;
    } seig_req_t;

    typedef struct packed {
        logic [63:0] last_time;
        logic [63:0] prev_seq;
        logic        have_last;
        logic [31:0] count;
    } seig_state_t;

    typedef struct packed {
        logic [63:0] id_time;
        logic [63:0] id_seq;
        status_t     status;
        logic [31:0] entry_total;
    } seig_res_t;

endpackage

@@ rtl/seig_core.sv @@
// Combinational ID selection and ordering check against the last ID.
module seig_core
    import seig_pkg::*;
(
    input  seig_req_t   req,
    input  seig_state_t state,
    output seig_res_t   res,
    output seig_state_t state_next
);

    logic [63:0] seq_inc;
    logic [63:0] cand_time;
    logic [63:0] cand_seq;
    logic [63:0] base_time;
    logic [63:0] base_seq;
    logic        is_zero;
    logic        is_greater;
    status_t     status;
    logic [31:0] count_next;

    assign seq_inc   = state.prev_seq + 64'd1;
    assign base_time = state.have_last ? state.last_time : 64'd0;
    assign base_seq  = state.have_last ? state.prev_seq : 64'd0;

    always_comb
    begin
        case (req.mode)
            MODE_PARTIAL:
            begin
                cand_time = req.req_time;
                if (state.have_last && (state.last_time == req.req_time))
                begin
                    cand_seq = seq_inc;
                end
                else
                begin
                    cand_seq = (req.req_time == 64'd0) ? 64'd1 : 64'd0;
                end
            end
            MODE_EXPLICIT:
            begin
                cand_time = req.req_time;
                cand_seq  = req.req_seq;
            end
            default:
            begin
                // auto: move forward with the clock, else bump the sequence
                if (req.now_ms > state.last_time)
                begin
                    cand_time = req.now_ms;
                    cand_seq  = 64'd0;
                end
                else
                begin
                    cand_time = state.last_time;
                    cand_seq  = seq_inc;
                end
            end
        endcase
    end

    assign is_zero    = (cand_time == 64'd0) && (cand_seq == 64'd0);
    assign is_greater = (cand_time != base_time) ? (cand_time > base_time)
                                                 : (cand_seq > base_seq);

    always_comb
    begin
        if (!req.has_fields)
        begin
            status = ST_NO_FIELD;
        end
        else if ((req.mode == MODE_PARTIAL) || (req.mode == MODE_EXPLICIT))
        begin
            if (is_zero)
            begin
                status = ST_ZERO_ID;
            end
            else if (!is_greater)
            begin
                status = ST_NOT_GT;
            end
            else
            begin
                status = ST_OK;
            end
        end
        else
        begin
            status = ST_OK;
        end
    end

    assign count_next = (state.count != COUNT_MAX) ? (state.count + 32'd1) : state.count;

    always_comb
    begin
        state_next = state;
        res.status = status;
        if (status == ST_OK)
        begin
            state_next.last_time = cand_time;
            state_next.prev_seq  = cand_seq;
            state_next.have_last = 1'b1;
            state_next.count     = count_next;
            res.id_time          = cand_time;
            res.id_seq           = cand_seq;
            res.entry_total      = count_next;
        end
        else
        begin
            res.id_time     = 64'd0;
            res.id_seq      = 64'd0;
            res.entry_total = state.count;
        end
    end

endmodule

@@ rtl/stream_entry_id_generator.sv @@
// out_valid rises when a request advances from the input register; the result transfer follows.
// Throughput: one request per cycle unless out_stall holds the result register; the last-ID
// registers update in the same cycle that a request moves from the input to the result register.
// Backpressure: the input register is taken whenever the result register is empty or drains.
// Reset: rst_n clears both valid flags, the last ID, the have-last flag and the entry count.
// Payload registers are not reset.
module stream_entry_id_generator
    import seig_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [63:0] req_time,
    input  logic [63:0] req_seq,
    input  logic [63:0] now_ms,
    input  logic        has_fields,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] id_time,
    output logic [63:0] id_seq,
    output logic [1:0]  status,
    output logic [31:0] entry_total
);

    // Input register stage
    logic        req_valid_reg;
    seig_req_t   req_reg;

    // Result register stage
    logic        res_valid_reg;
    seig_res_t   res_reg;

    // Last ID and entry count
    seig_state_t state_reg;
    seig_state_t state_next;
    seig_res_t   res_next;

    logic        res_free;
    logic        advance;
    logic        in_xfer;

    // The result register can take a new value when empty or when its transfer completes.
    assign res_free = !res_valid_reg || !out_stall;
    assign advance  = req_valid_reg && res_free;
    // Hold the input side only while the input register is full and cannot advance.
    assign in_stall = req_valid_reg && !res_free;
    assign in_xfer  = in_valid && !in_stall;

    seig_core u_core
    (
        .req        (req_reg),
        .state      (state_reg),
        .res        (res_next),
        .state_next (state_next)
    );

    // Valid flags and the last-ID state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                req_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg.mode       <= mode;
            req_reg.req_time   <= req_time;
            req_reg.req_seq    <= req_seq;
            req_reg.now_ms     <= now_ms;
            req_reg.has_fields <= has_fields;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = res_valid_reg;
    assign id_time     = res_reg.id_time;
    assign id_seq      = res_reg.id_seq;
    assign status      = res_reg.status;
    assign entry_total = res_reg.entry_total;

    // A failed request returns a zero ID.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status != ST_OK))
            |-> ((res_reg.id_time == 64'd0) && (res_reg.id_seq == 64'd0)))
        else $error("failed result carries a nonzero ID");

    // A successful result means the last ID is recorded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.status == ST_OK)) |-> state_reg.have_last)
        else $error("ok result without a recorded last ID");

    // State changes only when a request advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("last-ID state changed without a request");

    // The entry count never decreases.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (state_reg.count >= $past(state_reg.count)))
        else $error("entry count decreased");

    // Input stall only with a full input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> req_valid_reg)
        else $error("input stalled with empty input register");

endmodule
